// ===== src/mstim_pkg.sv =====
`timescale 1ns / 1ps

package mstim_pkg;

  // Field widths of one transfer on each channel
  localparam int OP_W     = 2;
  localparam int VAL_W    = 16;
  localparam int HANDLE_W = 4;
  localparam int MASK_W   = 8;
  localparam int TOTAL_W  = 4;

  // Default table size and its upper bound
  localparam int DEF_SLOT_COUNT = 8;
  localparam int MAX_SLOT_COUNT = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_INSTALL = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;       // capture the input transfer
    logic tick_start;  // snapshot the fire budget, rewind the slot pointer
    logic tick_step;   // visit the slot under the pointer
    logic exec;        // carry out install, remove or an unused op
    logic post;        // load the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic op_is_tick;  // captured op is a tick
    logic last_slot;   // pointer is at the highest slot
    logic out_free;    // output register can take a result this cycle
  } dp_status_t;

endpackage

// ===== src/mstim_if.sv =====
`timescale 1ns / 1ps

interface mstim_in_if;
  import mstim_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic [VAL_W-1:0]          period;
  logic signed [VAL_W-1:0]   shot_count;
  logic [HANDLE_W-1:0]       slot_handle;

  modport source (output valid, output op, output period, output shot_count,
                  output slot_handle, input ready);
  modport sink (input valid, input op, input period, input shot_count,
                input slot_handle, output ready);
endinterface

interface mstim_out_if;
  import mstim_pkg::*;

  logic                valid;
  logic                ready;
  logic [MASK_W-1:0]   fired_mask;
  logic [HANDLE_W-1:0] new_handle;
  logic                remove_ok;

  modport source (output valid, output fired_mask, output new_handle,
                  output remove_ok, input ready);
  modport sink (input valid, input fired_mask, input new_handle,
                input remove_ok, output ready);
endinterface

// ===== src/mstim_datapath.sv =====
`timescale 1ns / 1ps

module mstim_datapath #(
  parameter int SLOT_COUNT = mstim_pkg::DEF_SLOT_COUNT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [mstim_pkg::OP_W-1:0]             op,
  input  logic [mstim_pkg::VAL_W-1:0]            period,
  input  logic signed [mstim_pkg::VAL_W-1:0]     shot_count,
  input  logic [mstim_pkg::HANDLE_W-1:0]         slot_handle,
  input  mstim_pkg::dp_cmd_t                     cmd,
  output mstim_pkg::dp_status_t                  status,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic [mstim_pkg::MASK_W-1:0]           fired_mask,
  output logic [mstim_pkg::HANDLE_W-1:0]         new_handle,
  output logic                                   remove_ok
);
  import mstim_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Captured input transfer
  logic [OP_W-1:0]     op_q;
  logic [VAL_W-1:0]    period_q;
  logic [VAL_W-1:0]    shots_q;
  logic [HANDLE_W-1:0] handle_q;

  // Slot table
  logic [VAL_W-1:0] reload_value [SLOT_COUNT];
  logic [VAL_W-1:0] countdown    [SLOT_COUNT];
  logic [VAL_W-1:0] shots_left   [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] active_bits, active_bits_next;
  logic [SLOT_COUNT-1:0] claimed_bits, claimed_bits_next;
  logic [TOTAL_W-1:0]    active_total, active_total_next;

  // Tick walk and pending result
  logic [TOTAL_W-1:0]  budget;
  logic [IDX_W-1:0]    idx;
  logic [MASK_W-1:0]   fired;
  logic [HANDLE_W-1:0] res_handle;
  logic                res_ok;

  // Slot step decode
  logic [VAL_W-1:0]      cur_count;
  logic [VAL_W-1:0]      cur_shots;
  logic                  visit;
  logic                  fire;
  logic                  shots_finite;
  logic                  spent;
  logic [SLOT_COUNT-1:0] idx_bit;

  // Install and remove decode
  logic                  find_ok;
  logic [IDX_W-1:0]      find_idx;
  logic [SLOT_COUNT-1:0] find_bit;
  logic                  inst_do;
  logic                  rem_do;
  logic [HANDLE_W-1:0]   handle_m1;
  logic [IDX_W-1:0]      rem_idx;
  logic [SLOT_COUNT-1:0] rem_bit;

  assign cur_count    = countdown[idx];
  assign cur_shots    = shots_left[idx];
  assign idx_bit      = SLOT_COUNT'(1) << idx;
  assign visit        = cmd.tick_step && (budget != '0) && active_bits[idx];
  assign fire         = visit && (cur_count == '0);
  assign shots_finite = (cur_shots != '0) && !cur_shots[VAL_W-1];
  assign spent        = fire && shots_finite && (cur_shots == VAL_W'(1));

  // Find the lowest unclaimed slot
  always_comb begin
    find_ok  = 1'b0;
    find_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!find_ok && !claimed_bits[i]) begin
        find_ok  = 1'b1;
        find_idx = IDX_W'(i);
      end
    end
  end

  assign find_bit  = SLOT_COUNT'(1) << find_idx;
  assign inst_do   = cmd.exec && (op_q == OP_INSTALL) && (shots_q != '0) &&
                     (active_total < TOTAL_W'(SLOT_COUNT)) && find_ok;
  assign handle_m1 = handle_q - HANDLE_W'(1);
  assign rem_idx   = handle_m1[IDX_W-1:0];
  assign rem_bit   = SLOT_COUNT'(1) << rem_idx;
  assign rem_do    = cmd.exec && (op_q == OP_REMOVE) && (handle_q != '0) &&
                     (handle_q <= HANDLE_W'(SLOT_COUNT));

  // Next value of the slot bookkeeping
  always_comb begin
    active_bits_next  = active_bits;
    claimed_bits_next = claimed_bits;
    active_total_next = active_total;
    if (inst_do) begin
      active_bits_next  = active_bits | find_bit;
      claimed_bits_next = claimed_bits | find_bit;
      active_total_next = active_total + TOTAL_W'(1);
    end else if (rem_do) begin
      active_bits_next  = active_bits & ~rem_bit;
      claimed_bits_next = claimed_bits & ~rem_bit;
      if (active_total != '0) active_total_next = active_total - TOTAL_W'(1);
    end else if (spent) begin
      active_bits_next = active_bits & ~idx_bit;
      if (active_total != '0) active_total_next = active_total - TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bits  <= '0;
      claimed_bits <= '0;
      active_total <= '0;
    end else begin
      active_bits  <= active_bits_next;
      claimed_bits <= claimed_bits_next;
      active_total <= active_total_next;
    end
  end

  // Write the slot table: fill on install, count down or reload on tick
  always_ff @(posedge clk) begin
    if (inst_do) begin
      reload_value[find_idx] <= period_q;
      countdown[find_idx]    <= period_q;
      shots_left[find_idx]   <= shots_q;
    end else if (visit) begin
      if (fire) begin
        countdown[idx] <= reload_value[idx];
        if (shots_finite) shots_left[idx] <= cur_shots - VAL_W'(1);
      end else begin
        countdown[idx] <= cur_count - VAL_W'(1);
      end
    end
  end

  // Capture the input, walk the slots and build the result
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q     <= op;
      period_q <= period;
      shots_q  <= shot_count;
      handle_q <= slot_handle;
    end
    if (cmd.tick_start) begin
      budget     <= active_total;
      idx        <= '0;
      fired      <= '0;
      res_handle <= '0;
      res_ok     <= 1'b0;
    end
    if (cmd.exec) begin
      fired      <= '0;
      res_handle <= inst_do ? (HANDLE_W'(find_idx) + HANDLE_W'(1)) : '0;
      res_ok     <= rem_do;
    end
    if (cmd.tick_step) begin
      if (idx != IDX_W'(SLOT_COUNT - 1)) idx <= idx + IDX_W'(1);
      if (fire) begin
        budget <= budget - TOTAL_W'(1);
        fired  <= fired | (MASK_W'(1) << idx);
      end
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.post) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      fired_mask <= fired;
      new_handle <= res_handle;
      remove_ok  <= res_ok;
    end
  end

  assign status.op_is_tick = (op_q == OP_TICK);
  assign status.last_slot  = (idx == IDX_W'(SLOT_COUNT - 1));
  assign status.out_free   = !result_valid || result_ready;

endmodule

// ===== src/mstim_ctrl.sv =====
`timescale 1ns / 1ps

module mstim_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mstim_pkg::dp_status_t status,
  output mstim_pkg::dp_cmd_t    cmd
);
  import mstim_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_TICK   = 4'b0100,
    S_POST   = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Sequence one item: capture, decode, walk or execute, post
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.op_is_tick) begin
          cmd.tick_start = 1'b1;
          state_next     = S_TICK;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_POST;
        end
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (status.last_slot) state_next = S_POST;
      end
      S_POST: begin
        if (status.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/multi_slot_software_timer_unit.sv =====
`timescale 1ns / 1ps

// Table of SLOT_COUNT software timer slots driven by one operation per input
// transfer: tick, install or remove, with exactly one result per input.
// Install takes the lowest unclaimed slot and returns its one-based handle
// (0 on failure); remove frees a slot by handle; tick visits active slots in
// ascending order with a fire budget equal to the active count at its start
// and returns the mask of slots that fired. Install, remove and unused ops
// execute in the decode state and then post; a tick walks the slots after
// decode, one slot per cycle through the shared countdown update, then posts.
// The next input is taken once the result has moved into the output
// register, even while that result still waits downstream.
module multi_slot_software_timer_unit #(
  parameter int SLOT_COUNT = mstim_pkg::DEF_SLOT_COUNT
) (
  input  logic       clk,
  input  logic       rst,
  mstim_in_if.sink   item,
  mstim_out_if.source result
);
  import mstim_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign item.ready = in_ready;

  mstim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mstim_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .op           (item.op),
    .period       (item.period),
    .shot_count   (item.shot_count),
    .slot_handle  (item.slot_handle),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .fired_mask   (result.fired_mask),
    .new_handle   (result.new_handle),
    .remove_ok    (result.remove_ok)
  );

endmodule

// ===== dv/multi_slot_software_timer_unit_tb.sv =====
`timescale 1ns / 1ps

module multi_slot_software_timer_unit_tb;
  import mstim_pkg::*;

  localparam int SLOTS = DEF_SLOT_COUNT;
  localparam int SETTLE_CYCLES = 3 * (SLOTS + 3);
  localparam int RANDOM_PER_PHASE = 430;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [VAL_W-1:0]        period;
    logic signed [VAL_W-1:0] shot_count;
    logic [HANDLE_W-1:0]     slot_handle;
    bit                      drain_first;
  } timer_op_t;

  typedef struct {
    logic [MASK_W-1:0]   fired_mask;
    logic [HANDLE_W-1:0] new_handle;
    logic                remove_ok;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mstim_in_if  in_ch ();
  mstim_out_if out_ch ();

  multi_slot_software_timer_unit #(
    .SLOT_COUNT(SLOTS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch)
  );

  // Timer table mirror
  logic [SLOTS-1:0]        slot_active;
  logic [SLOTS-1:0]        slot_claimed;
  logic [TOTAL_W-1:0]      live_total;
  logic [VAL_W-1:0]        slot_reload [SLOTS];
  logic [VAL_W-1:0]        slot_count [SLOTS];
  logic signed [VAL_W-1:0] slot_shots [SLOTS];

  timer_op_t     op_backlog [$];
  timer_result_t owed_results [$];
  int            n_queued = 0;
  int            n_accepted = 0;
  int            error_count = 0;
  int            src_idle_pct = 0;
  int            snk_idle_pct = 0;
  bit            in_taken = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one operation to the mirror and return what the block should report
  function automatic timer_result_t timer_table_step(timer_op_t t);
    timer_result_t res;
    logic [TOTAL_W-1:0] budget;
    bit placed;
    res = '{default: '0};
    placed = 1'b0;
    case (t.op)
      OP_TICK: begin
        budget = live_total;
        for (int s = 0; s < SLOTS; s++) begin
          if (budget != 0 && slot_active[s]) begin
            if (slot_count[s] != 0) begin
              slot_count[s] = slot_count[s] - 1'b1;
            end else begin
              budget = budget - 1'b1;
              res.fired_mask[s] = 1'b1;
              slot_count[s] = slot_reload[s];
              if (slot_shots[s] > 0) begin
                slot_shots[s] = slot_shots[s] - 16'sd1;
                if (slot_shots[s] == 0) begin
                  slot_active[s] = 1'b0;
                  if (live_total != 0) live_total = live_total - 1'b1;
                end
              end
            end
          end
        end
      end
      OP_INSTALL: begin
        if (t.shot_count != 0 && live_total < SLOTS) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!placed && !slot_claimed[s]) begin
              placed = 1'b1;
              slot_reload[s] = t.period;
              slot_count[s] = t.period;
              slot_shots[s] = t.shot_count;
              slot_claimed[s] = 1'b1;
              slot_active[s] = 1'b1;
              live_total = live_total + 1'b1;
              res.new_handle = HANDLE_W'(s + 1);
            end
          end
        end
      end
      OP_REMOVE: begin
        if (t.slot_handle != 0 && t.slot_handle <= SLOTS) begin
          slot_active[t.slot_handle - 1] = 1'b0;
          slot_claimed[t.slot_handle - 1] = 1'b0;
          if (live_total != 0) live_total = live_total - 1'b1;
          res.remove_ok = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_op(logic [OP_W-1:0] op, logic [VAL_W-1:0] period,
                          logic signed [VAL_W-1:0] shots,
                          logic [HANDLE_W-1:0] handle, bit drain);
    timer_op_t t;
    t.op = op;
    t.period = period;
    t.shot_count = shots;
    t.slot_handle = handle;
    t.drain_first = drain;
    op_backlog.push_back(t);
    n_queued++;
  endtask

  // Mostly ticks and short-lived installs so slots fire, spend and recycle
  function automatic timer_op_t random_timer_op();
    timer_op_t t;
    int pick;
    int shape;
    logic [VAL_W-1:0] raw;
    t.period = VAL_W'($urandom);
    t.shot_count = VAL_W'($urandom);
    t.slot_handle = HANDLE_W'($urandom);
    t.drain_first = 1'b0;
    pick = $urandom_range(99);
    shape = $urandom_range(99);
    if (pick < 50) begin
      t.op = OP_TICK;
    end else if (pick < 75) begin
      t.op = OP_INSTALL;
      if ($urandom_range(99) < 85) t.period = VAL_W'($urandom_range(0, 4));
      if (shape < 40) begin
        t.shot_count = VAL_W'($urandom_range(1, 3));
      end else if (shape < 70) begin
        raw = VAL_W'($urandom_range(0, 4));
        t.shot_count = ~raw;
      end else if (shape < 80) begin
        t.shot_count = '0;
      end
    end else if (pick < 97) begin
      t.op = OP_REMOVE;
      if (shape < 85) t.slot_handle = HANDLE_W'($urandom_range(1, SLOTS));
    end else begin
      t.op = OP_UNUSED;
    end
    return t;
  endfunction

  // Capture accepted operations and check results at the rising edge
  always @(posedge clk) begin : mon
    timer_op_t     seen;
    timer_result_t want;
    in_taken = !rst && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      seen.op = in_ch.op;
      seen.period = in_ch.period;
      seen.shot_count = in_ch.shot_count;
      seen.slot_handle = in_ch.slot_handle;
      seen.drain_first = 1'b0;
      owed_results.push_back(timer_table_step(seen));
      n_accepted++;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual mask %h handle %0d ok %0b",
                 $time, out_ch.fired_mask, out_ch.new_handle, out_ch.remove_ok);
      end else begin
        want = owed_results.pop_front();
        if (out_ch.fired_mask !== want.fired_mask) begin
          error_count++;
          $display("%0t: fired_mask mismatch: expected %h, actual %h",
                   $time, want.fired_mask, out_ch.fired_mask);
        end
        if (out_ch.new_handle !== want.new_handle) begin
          error_count++;
          $display("%0t: new_handle mismatch: expected %0d, actual %0d",
                   $time, want.new_handle, out_ch.new_handle);
        end
        if (out_ch.remove_ok !== want.remove_ok) begin
          error_count++;
          $display("%0t: remove_ok mismatch: expected %0b, actual %0b",
                   $time, want.remove_ok, out_ch.remove_ok);
        end
      end
    end
  end

  // Drive the next operation at the falling edge once the last one transferred
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (op_backlog.size() == 0 || $urandom_range(99) < src_idle_pct ||
          (op_backlog[0].drain_first && owed_results.size() != 0)) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.op <= op_backlog[0].op;
        in_ch.period <= op_backlog[0].period;
        in_ch.shot_count <= op_backlog[0].shot_count;
        in_ch.slot_handle <= op_backlog[0].slot_handle;
        in_ch.valid <= 1'b1;
        void'(op_backlog.pop_front());
      end
    end
  end

  initial begin
    timer_op_t t;
    in_ch.valid = 1'b0;
    in_ch.op = OP_TICK;
    in_ch.period = '0;
    in_ch.shot_count = '0;
    in_ch.slot_handle = '0;
    out_ch.ready = 1'b0;
    slot_active = '0;
    slot_claimed = '0;
    live_total = '0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_reload[s] = '0;
      slot_count[s] = '0;
      slot_shots[s] = '0;
    end
    src_idle_pct = 19;
    snk_idle_pct = 82;

    // Directed: empty tick, rejected install, field extremes, bad handles
    queue_op(OP_TICK, 16'hFFFF, 16'sh7FFF, 4'hF, 1'b0);
    queue_op(OP_INSTALL, 16'd5, 16'sd0, 4'd0, 1'b0);
    queue_op(OP_INSTALL, 16'd0, 16'sd1, 4'd0, 1'b0);
    queue_op(OP_INSTALL, 16'd0, -16'sd1, 4'd0, 1'b0);
    queue_op(OP_INSTALL, 16'hFFFF, 16'sh7FFF, 4'd0, 1'b0);
    queue_op(OP_INSTALL, 16'd2, 16'sh8000, 4'd0, 1'b0);
    queue_op(OP_TICK, 16'd0, 16'sd0, 4'd0, 1'b0);
    queue_op(OP_TICK, 16'd0, 16'sd0, 4'd0, 1'b0);
    queue_op(OP_REMOVE, 16'd0, 16'sd0, 4'd0, 1'b0);
    queue_op(OP_REMOVE, 16'd0, 16'sd0, 4'd9, 1'b0);
    queue_op(OP_REMOVE, 16'd0, 16'sd0, 4'hF, 1'b0);
    // Spent slot is idle but claimed; removing it still lowers the count
    queue_op(OP_REMOVE, 16'd0, 16'sd0, 4'd1, 1'b0);
    queue_op(OP_UNUSED, 16'hFFFF, 16'shFFFF, 4'hF, 1'b0);
    // Fill the table, then try one more install
    for (int i = 0; i < 5; i++) queue_op(OP_INSTALL, 16'd1, 16'sd2, 4'd0, 1'b0);
    queue_op(OP_INSTALL, 16'd1, 16'sd2, 4'd0, 1'b0);
    // Idle removes shrink the budget below the active count
    queue_op(OP_REMOVE, 16'd0, 16'sd0, 4'd8, 1'b0);
    queue_op(OP_REMOVE, 16'd0, 16'sd0, 4'd8, 1'b0);
    queue_op(OP_REMOVE, 16'd0, 16'sd0, 4'd8, 1'b0);
    queue_op(OP_TICK, 16'd0, 16'sd0, 4'd0, 1'b0);
    queue_op(OP_TICK, 16'd0, 16'sd0, 4'd0, 1'b0);
    queue_op(OP_TICK, 16'd0, 16'sd0, 4'd0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Three idle profiles, each with one pause that lets results drain
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle_pct = 82;
        snk_idle_pct = 19;
      end else if (phase == 2) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        t = random_timer_op();
        queue_op(t.op, t.period, t.shot_count, t.slot_handle,
                 i == RANDOM_PER_PHASE / 2);
      end
      while (n_accepted != n_queued) @(posedge clk);
    end

    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop if the handshake stalls
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
